@@ design/itaf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types and constants for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int VAL_W         = 64;
  localparam int DIG_W         = 4;
  localparam int NUM_DIGITS    = 20;
  localparam int BCD_W         = NUM_DIGITS * DIG_W;
  localparam int BIT_CNT_W     = $clog2(VAL_W);
  localparam int ND_W          = $clog2(NUM_DIGITS + 1);
  localparam int FIELD_W       = 6;
  localparam int CNT_W         = 7;
  localparam int CHAR_W        = 8;
  localparam int MAX_FIELD_DEF = 62;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_NUL     = 8'h00;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_PLUS    = 8'h2B;
  localparam char_t CH_MINUS   = 8'h2D;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    KIND_SDEC = 2'd0,
    KIND_UDEC = 2'd1,
    KIND_HEXL = 2'd2,
    KIND_HEXU = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LEN_32 = 2'd0,
    LEN_16 = 2'd1,
    LEN_64 = 2'd2
  } len_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic hex;
    logic step;
    logic shift;
  } dig_ctrl_t;

  typedef struct packed {
    logic               sign_en;
    char_t              sign_char;
    logic               pad_left;
    char_t              pad_char;
    logic [FIELD_W-1:0] pad;
    logic [FIELD_W-1:0] zeros;
    logic [ND_W-1:0]    nd;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   room;
    logic               upper;
  } emit_job_t;

endpackage

@@ design/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// One printf-style integer conversion per input transfer, decimal or hex,
// emitted as ASCII characters one per output transfer.
//
// Input channel in_*: one conversion request per transfer (value, kind,
// length, flags, width, precision, room left). Output channel out_*: one
// character per transfer, tlast on the final one, tuser marks overflow (no
// character, always last). A conversion that formats to nothing gives no
// output transfer.
// Decimal requests run bit-serial BCD conversion in the digit shift
// register, then drop up to 20 leading digits (19 for decimal) and pass
// a sizing state; hex skips the conversion. Characters then leave at one
// per cycle while out_tready allows, up to 63; the next request is taken
// once the last character sits in the output register.
// Reset empties the output register and returns to idle. A stall on out_*
// holds the current character and pauses the sequencer.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int MAX_FIELD = itaf_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[63:0], flag_minus[64], flag_plus[65], flag_space[66], flag_zero[67],
  // pad_width[73:68], digit_precision[80:74], space_left[87:81]
  input  logic [87:0] in_tdata,
  // req_type[1:0], value_length[3:2]
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_char[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // overflow[0]
  output logic        out_tuser
);
  import itaf_pkg::*;

  state_t state_r, state_nxt;

  logic [VAL_W-1:0]   value_in;
  logic [VAL_W-1:0]   fit_in;
  logic [VAL_W-1:0]   mag_in;
  logic               signed_in;
  logic               hex_in;
  logic               neg_in;
  logic [6:0]         prec_raw;
  logic [FIELD_W-1:0] prec_in;
  logic [FIELD_W-1:0] width_raw;
  logic [FIELD_W-1:0] width_in;
  logic               accept;

  logic               hex_r;
  logic               upper_r;
  logic               sign_en_r;
  char_t              sign_char_r;
  logic               fminus_r;
  logic               fzero_r;
  logic [FIELD_W-1:0] width_r;
  logic               prec_def_r;
  logic [FIELD_W-1:0] prec_r;
  logic [CNT_W-1:0]   room_r;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;

  logic [DIG_W-1:0]   top_digit;
  logic               norm_go;
  logic [FIELD_W-1:0] nd_f;
  logic [FIELD_W-1:0] zeros;
  logic [FIELD_W-1:0] field;
  logic [FIELD_W-1:0] pad;
  logic [CNT_W-1:0]   total;

  dig_ctrl_t          dig_ctrl;
  emit_job_t          job;
  logic               emit_start;
  logic               dig_shift;
  logic               emit_done;

  assign value_in  = in_tdata[63:0];
  assign signed_in = (in_tuser[1:0] == KIND_SDEC);
  assign hex_in    = (in_tuser[1:0] == KIND_HEXL) || (in_tuser[1:0] == KIND_HEXU);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    unique case (in_tuser[3:2])
      LEN_32:  fit_in = {{32{signed_in & value_in[31]}}, value_in[31:0]};
      LEN_16:  fit_in = {{48{signed_in & value_in[15]}}, value_in[15:0]};
      default: fit_in = value_in;
    endcase
  end

  assign neg_in = signed_in && fit_in[VAL_W-1];
  assign mag_in = neg_in ? (VAL_W'(0) - fit_in) : fit_in;

  assign prec_raw  = in_tdata[80:74];
  assign prec_in   = (prec_raw[5:0] > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD)
                                                          : prec_raw[5:0];
  assign width_raw = in_tdata[73:68];
  assign width_in  = (width_raw > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : width_raw;

  always_ff @(posedge clk) begin
    if (accept) begin
      hex_r      <= hex_in;
      upper_r    <= (in_tuser[1:0] == KIND_HEXU);
      sign_en_r  <= neg_in || in_tdata[65] || in_tdata[66];
      if (neg_in) begin
        sign_char_r <= CH_MINUS;
      end else if (in_tdata[65]) begin
        sign_char_r <= CH_PLUS;
      end else begin
        sign_char_r <= CH_SPACE;
      end
      fminus_r   <= in_tdata[64];
      fzero_r    <= in_tdata[67];
      width_r    <= width_in;
      prec_def_r <= prec_raw[6];
      prec_r     <= prec_in;
      room_r     <= in_tdata[87:81];
    end
  end

  assign norm_go = (hex_r && !prec_def_r) ? (FIELD_W'(nd_r) > prec_r)
                                          : ((nd_r > ND_W'(1)) && (top_digit == '0));

  assign nd_f  = FIELD_W'(nd_r);
  assign zeros = (!prec_def_r && (prec_r > nd_f)) ? (prec_r - nd_f) : '0;
  assign field = nd_f + zeros;
  assign pad   = (!hex_r && (width_r > field)) ? (width_r - field) : '0;
  assign total = CNT_W'(sign_en_r) + CNT_W'(pad) + CNT_W'(field);

  always_comb begin
    job.sign_en   = sign_en_r;
    job.sign_char = sign_char_r;
    job.pad_left  = !fminus_r;
    job.pad_char  = (fzero_r && !fminus_r) ? CH_ZERO : CH_SPACE;
    job.pad       = pad;
    job.zeros     = zeros;
    job.nd        = nd_r;
    job.total     = total;
    job.room      = room_r;
    job.upper     = upper_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = hex_in ? ST_NORM : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == BIT_CNT_W'(VAL_W - 1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!norm_go) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_nxt = (total == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    dig_ctrl.load  = accept;
    dig_ctrl.hex   = hex_in;
    dig_ctrl.step  = (state_r == ST_CONV);
    dig_ctrl.shift = ((state_r == ST_NORM) && norm_go) || dig_shift;
    emit_start     = (state_r == ST_SIZE) && (total != '0);
  end

  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    nd_nxt      = nd_r;
    if (accept) begin
      bit_cnt_nxt = '0;
      nd_nxt      = ND_W'(NUM_DIGITS);
    end else begin
      if (state_r == ST_CONV) begin
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
      end
      if ((state_r == ST_NORM) && norm_go) begin
        nd_nxt = nd_r - ND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r <= bit_cnt_nxt;
    nd_r      <= nd_nxt;
  end

  itaf_digits u_digits (
    .clk       (clk),
    .ctrl      (dig_ctrl),
    .mag       (mag_in),
    .top_digit (top_digit)
  );

  itaf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .job        (job),
    .dig_top    (top_digit),
    .dig_shift  (dig_shift),
    .done       (emit_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ design/itaf_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_digits
// Digit shift register: bit-serial binary to BCD conversion (shift and add
// three), hex nibble load, and a digit-wide shift toward the top.
// ----------------------------------------------------------------------------
module itaf_digits (
  input  logic                      clk,
  input  itaf_pkg::dig_ctrl_t       ctrl,
  input  logic [itaf_pkg::VAL_W-1:0] mag,
  output logic [itaf_pkg::DIG_W-1:0] top_digit
);
  import itaf_pkg::*;

  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [VAL_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W];
      end
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    mag_nxt = mag_r;
    if (ctrl.load) begin
      mag_nxt = mag;
      if (ctrl.hex) begin
        bcd_nxt = {{(BCD_W-VAL_W){1'b0}}, mag};
      end else begin
        bcd_nxt = '0;
      end
    end else if (ctrl.step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VAL_W-1]};
      mag_nxt = {mag_r[VAL_W-2:0], 1'b0};
    end else if (ctrl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    mag_r <= mag_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIG_W];

endmodule

@@ design/itaf_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_emit
// Character sequencer and output stage: sign, left padding, leading zeros,
// digits and right padding, one character per transfer, with room check.
// ----------------------------------------------------------------------------
module itaf_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  itaf_pkg::emit_job_t        job,
  input  logic [itaf_pkg::DIG_W-1:0] dig_top,
  output logic                       dig_shift,
  output logic                       done,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // out_char[7:0]
  output logic                       out_tlast,
  output logic                       out_tuser   // overflow
);
  import itaf_pkg::*;

  function automatic char_t digit_char(input logic [DIG_W-1:0] d, input logic upper);
    char_t base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < DIG_W'(10)) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return base + CHAR_W'(d) - CHAR_W'(10);
  endfunction

  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               sign_pend_r, sign_pend_nxt;
  char_t              sign_char_r, sign_char_nxt;
  logic               pad_left_r, pad_left_nxt;
  char_t              pad_char_r, pad_char_nxt;
  logic [FIELD_W-1:0] pad_r, pad_nxt;
  logic [FIELD_W-1:0] zeros_r, zeros_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   room_r, room_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic               upper_r, upper_nxt;
  char_t              out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               fire;
  logic               is_last;

  assign fire    = busy_r && (!out_valid_r || out_tready);
  assign is_last = (k_r == total_r - CNT_W'(1));

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sign_pend_nxt = sign_pend_r;
    sign_char_nxt = sign_char_r;
    pad_left_nxt  = pad_left_r;
    pad_char_nxt  = pad_char_r;
    pad_nxt       = pad_r;
    zeros_nxt     = zeros_r;
    nd_nxt        = nd_r;
    total_nxt     = total_r;
    room_nxt      = room_r;
    k_nxt         = k_r;
    upper_nxt     = upper_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    dig_shift     = 1'b0;
    done          = 1'b0;

    if (start) begin
      busy_nxt      = 1'b1;
      k_nxt         = '0;
      sign_pend_nxt = job.sign_en;
      sign_char_nxt = job.sign_char;
      pad_left_nxt  = job.pad_left;
      pad_char_nxt  = job.pad_char;
      pad_nxt       = job.pad;
      zeros_nxt     = job.zeros;
      nd_nxt        = job.nd;
      total_nxt     = job.total;
      room_nxt      = job.room;
      upper_nxt     = job.upper;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      k_nxt         = k_r + CNT_W'(1);
      if (k_r >= room_r) begin
        out_data_nxt = CH_NUL;
        out_last_nxt = 1'b1;
        out_ovf_nxt  = 1'b1;
        busy_nxt     = 1'b0;
        done         = 1'b1;
      end else begin
        out_ovf_nxt  = 1'b0;
        out_last_nxt = is_last;
        if (is_last) begin
          busy_nxt = 1'b0;
          done     = 1'b1;
        end
        if (sign_pend_r) begin
          out_data_nxt  = sign_char_r;
          sign_pend_nxt = 1'b0;
        end else if (pad_left_r && (pad_r != '0)) begin
          out_data_nxt = pad_char_r;
          pad_nxt      = pad_r - FIELD_W'(1);
        end else if (zeros_r != '0) begin
          out_data_nxt = CH_ZERO;
          zeros_nxt    = zeros_r - FIELD_W'(1);
        end else if (nd_r != '0) begin
          out_data_nxt = digit_char(dig_top, upper_r);
          nd_nxt       = nd_r - ND_W'(1);
          dig_shift    = 1'b1;
        end else begin
          out_data_nxt = CH_SPACE;
          pad_nxt      = pad_r - FIELD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_char_r <= sign_char_nxt;
    pad_left_r  <= pad_left_nxt;
    pad_char_r  <= pad_char_nxt;
    pad_r       <= pad_nxt;
    zeros_r     <= zeros_nxt;
    nd_r        <= nd_nxt;
    total_r     <= total_nxt;
    room_r      <= room_nxt;
    k_r         <= k_nxt;
    upper_r     <= upper_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
